### src/vt4_pkg.sv
`timescale 1ns / 1ps
package vt4_pkg;

   localparam int DATA_W                = 32;
   localparam int CFG_W                 = 2 * DATA_W;
   localparam int CSR_INDEX_W           = 8;
   localparam int ROWS                  = 4;
   localparam int COLS                  = 4;
   localparam int LANES                 = ROWS;
   localparam int ROW_SEL_W             = $clog2(ROWS);
   localparam int REG_COUNT             = ROWS * COLS / 2;
   localparam int PROD_W                = 2 * DATA_W;
   localparam int PAIR_W                = PROD_W + 1;
   localparam int SUM_W                 = PROD_W + 2;
   localparam int DEFAULT_FRACTION_BITS = 16;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef fix_type [COLS-1:0]       row_type;
   typedef row_type [ROWS-1:0]       matrix_type;
   typedef fix_type [COLS-1:0]       vertex_type;
   typedef fix_type [LANES-1:0]      result_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [LANES-1:0]      sums_type;

   // Load enables for the three registered stages of every lane.
   typedef struct packed {
      logic mul_en;
      logic pair_en;
      logic sum_en;
   } lane_ctl_type;

   localparam fix_type FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

### src/vt4_if.sv
`timescale 1ns / 1ps
interface vt4_req_if;
   import vt4_pkg::*;
   logic    valid;
   logic    ready;
   fix_type vx;
   fix_type vy;
   fix_type vz;
   fix_type vw;
   modport source (output valid, output vx, output vy, output vz, output vw, input ready);
   modport sink (input valid, input vx, input vy, input vz, input vw, output ready);
endinterface

interface vt4_rsp_if;
   import vt4_pkg::*;
   logic    valid;
   logic    ready;
   fix_type ox;
   fix_type oy;
   fix_type oz;
   fix_type ow;
   modport source (output valid, output ox, output oy, output oz, output ow, input ready);
   modport sink (input valid, input ox, input oy, input oz, input ow, output ready);
endinterface

interface vt4_csr_if;
   import vt4_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CFG_W-1:0]       data;
   modport source (output valid, output reg_index, output data, input ready);
   modport sink (input valid, input reg_index, input data, output ready);
endinterface

### src/vt4_csr.sv
`timescale 1ns / 1ps
module vt4_csr #(
   parameter int FRACTION_BITS = vt4_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   vt4_csr_if.sink             csr_ch,
   output vt4_pkg::matrix_type matrix
);
   import vt4_pkg::*;

   localparam fix_type ONE = fix_type'(1) << FRACTION_BITS;

   matrix_type            matrix_ff;
   logic [ROW_SEL_W-1:0]  row_sel;
   logic                  half_sel;

   // Register k holds row k/2, columns 2*(k%2) and 2*(k%2)+1.
   assign row_sel  = csr_ch.reg_index[ROW_SEL_W:1];
   assign half_sel = csr_ch.reg_index[0];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               matrix_ff[r][c] <= (r == c) ? ONE : '0;
            end
         end
      end else if (csr_ch.valid && (csr_ch.reg_index < CSR_INDEX_W'(REG_COUNT))) begin
         if (half_sel) begin
            matrix_ff[row_sel][2] <= csr_ch.data[DATA_W-1:0];
            matrix_ff[row_sel][3] <= csr_ch.data[CFG_W-1:DATA_W];
         end else begin
            matrix_ff[row_sel][0] <= csr_ch.data[DATA_W-1:0];
            matrix_ff[row_sel][1] <= csr_ch.data[CFG_W-1:DATA_W];
         end
      end
   end

   assign matrix = matrix_ff;

endmodule

### src/vt4_lane.sv
`timescale 1ns / 1ps
module vt4_lane (
   input  logic                  clock,
   input  vt4_pkg::row_type      row,
   input  vt4_pkg::vertex_type   vertex,
   input  vt4_pkg::lane_ctl_type ctl,
   output vt4_pkg::sum_type      sum
);
   import vt4_pkg::*;

   prod_type [COLS-1:0] prod_ff, prod_in;
   pair_type [1:0]      pair_ff, pair_in;
   sum_type             sum_ff,  sum_in;

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         prod_in[c] = $signed(row[c]) * $signed(vertex[c]);
      end
      pair_in[0] = PAIR_W'($signed(prod_ff[0])) + PAIR_W'($signed(prod_ff[1]));
      pair_in[1] = PAIR_W'($signed(prod_ff[2])) + PAIR_W'($signed(prod_ff[3]));
      sum_in     = SUM_W'($signed(pair_ff[0])) + SUM_W'($signed(pair_ff[1]));
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.pair_en) begin
         pair_ff <= pair_in;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

### src/vt4_merge.sv
`timescale 1ns / 1ps
module vt4_merge #(
   parameter int FRACTION_BITS = vt4_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  vt4_pkg::sums_type sums,
   output logic              out_free,
   vt4_rsp_if.source         rsp_ch
);
   import vt4_pkg::*;

   result_type result_ff, result_in;
   logic       valid_ff,  valid_in;
   sum_type    shifted;

   // Floor shift, then clamp whenever the bits above the result's sign
   // disagree with it.
   always_comb begin
      shifted = '0;
      for (int l = 0; l < LANES; l++) begin
         shifted = $signed(sums[l]) >>> FRACTION_BITS;
         if ((&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1])) begin
            result_in[l] = shifted[DATA_W-1:0];
         end else begin
            result_in[l] = shifted[SUM_W-1] ? FIX_MIN : FIX_MAX;
         end
      end
   end

   assign out_free = !valid_ff || rsp_ch.ready;
   assign valid_in = out_free ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.ox    = result_ff[0];
   assign rsp_ch.oy    = result_ff[1];
   assign rsp_ch.oz    = result_ff[2];
   assign rsp_ch.ow    = result_ff[3];

endmodule

### src/vertex_transform_4x4.sv
`timescale 1ns / 1ps
// Transforms one homogeneous vertex (vx, vy, vz, vw) per item by a 4x4 matrix and returns
// (ox, oy, oz, ow), all signed fixed point with FRACTION_BITS fraction bits (Q16.16 by
// default). Each output is one matrix row dotted with the vertex: the four 32x32 products
// are kept exact, summed exactly, shifted right by FRACTION_BITS with rounding toward minus
// infinity, and saturated to 32 bits. The matrix sits in eight 64-bit registers written by
// index 0..7 on the csr channel (two entries per register, the lower column in bits 31:0);
// reset loads the identity, and writes to indexes beyond seven are dropped. Write the matrix
// only while no item is in flight. The block accepts one item every cycle unless a stalled
// output has filled the pipeline; an accepted item is loaded into the multiplier bank and
// then moves through the pairwise adds, the final add and the saturating output register,
// whose contents are the valid result.
// Four identical lanes, one per matrix row, each carry four 32x32 multipliers; a stalled
// output only holds back the stages behind it, so bubbles in the pipeline are squeezed out.
module vertex_transform_4x4 #(
   parameter int FRACTION_BITS = vt4_pkg::DEFAULT_FRACTION_BITS
) (
   input logic       clock,
   input logic       reset,
   vt4_req_if.sink   req_ch,
   vt4_rsp_if.source rsp_ch,
   vt4_csr_if.sink   csr_ch
);
   import vt4_pkg::*;

   matrix_type   matrix;
   vertex_type   vertex;
   sums_type     sums;
   lane_ctl_type lane_ctl;
   logic         out_free;

   // Occupancy of the product, pair-sum and final-sum stages.
   logic mul_valid_ff,  mul_valid_in;
   logic pair_valid_ff, pair_valid_in;
   logic sum_valid_ff,  sum_valid_in;

   vt4_csr #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_csr (
      .clock (clock),
      .reset (reset),
      .csr_ch(csr_ch),
      .matrix(matrix)
   );

   assign vertex = {req_ch.vw, req_ch.vz, req_ch.vy, req_ch.vx};

   // A stage may load when it is empty or when its contents move on this cycle.
   assign lane_ctl.sum_en  = !sum_valid_ff  || out_free;
   assign lane_ctl.pair_en = !pair_valid_ff || lane_ctl.sum_en;
   assign lane_ctl.mul_en  = !mul_valid_ff  || lane_ctl.pair_en;

   assign req_ch.ready = lane_ctl.mul_en;

   assign mul_valid_in  = lane_ctl.mul_en  ? req_ch.valid  : mul_valid_ff;
   assign pair_valid_in = lane_ctl.pair_en ? mul_valid_ff  : pair_valid_ff;
   assign sum_valid_in  = lane_ctl.sum_en  ? pair_valid_ff : sum_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff  <= 1'b0;
         pair_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         mul_valid_ff  <= mul_valid_in;
         pair_valid_ff <= pair_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   // One lane per matrix row; all lanes see the same vertex and advance together.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vt4_lane u_lane (
         .clock (clock),
         .row   (matrix[l]),
         .vertex(vertex),
         .ctl   (lane_ctl),
         .sum   (sums[l])
      );
   end

   vt4_merge #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .in_valid(sum_valid_ff),
      .sums    (sums),
      .out_free(out_free),
      .rsp_ch  (rsp_ch)
   );

   // An accepted item always occupies the product stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> mul_valid_ff)
      else $error("accepted item did not reach the product stage");

   // A result only appears when the final-sum stage held an item.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(sum_valid_ff))
      else $error("result appeared without a finished sum");

   // An empty product stage never refuses an item.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !mul_valid_ff |-> req_ch.ready)
      else $error("input stalled with an empty product stage");

   // A full pipeline facing a stalled output must hold everything.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff && pair_valid_ff && sum_valid_ff && rsp_ch.valid && !rsp_ch.ready
      |-> !req_ch.ready)
      else $error("input accepted into a full, stalled pipeline");

endmodule

### tb/vt4_transform_checker.sv
`timescale 1ns / 1ps
// Watches the vertex, result and register channels. It keeps its own copy of the matrix,
// works out the transformed vertex for every accepted item and compares every accepted
// result with the oldest outstanding one.
module vt4_transform_checker #(
   parameter int FRACTION_BITS = vt4_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic clock,
   input  logic reset,
   vt4_req_if   req_ch,
   vt4_rsp_if   rsp_ch,
   vt4_csr_if   csr_ch,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   import vt4_pkg::*;

   localparam fix_type ONE_Q16     = 32'sh0001_0000;
   localparam int      MAX_PRINTED = 40;

   matrix_type coeffs;
   result_type expected_results[$];
   string      lane_names[LANES] = '{"ox", "oy", "oz", "ow"};

   function automatic matrix_type identity_matrix();
      matrix_type m;
      m = '0;
      for (int r = 0; r < ROWS; r++) begin
         m[r][r] = ONE_Q16;
      end
      return m;
   endfunction

   // Exact dot products, floor shift by the fraction width, then clamp to 32 bits.
   function automatic result_type transform_vertex(matrix_type m, vertex_type v);
      sum_type    acc;
      sum_type    shifted;
      prod_type   p;
      result_type r;
      for (int row = 0; row < ROWS; row++) begin
         acc = '0;
         for (int col = 0; col < COLS; col++) begin
            p   = $signed(m[row][col]) * $signed(v[col]);
            acc = acc + p;
         end
         shifted = acc >>> FRACTION_BITS;
         if (shifted > $signed(FIX_MAX)) begin
            r[row] = FIX_MAX;
         end else if (shifted < $signed(FIX_MIN)) begin
            r[row] = FIX_MIN;
         end else begin
            r[row] = shifted[DATA_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTED) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      vertex_type v;
      result_type got;
      result_type want;
      int         row;
      int         half;
      if (reset) begin
         coeffs = identity_matrix();
         expected_results.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         // Writes to indexes past the last register are dropped by the block.
         if (csr_ch.valid && csr_ch.ready && csr_ch.reg_index < REG_COUNT) begin
            row  = csr_ch.reg_index >> 1;
            half = csr_ch.reg_index & 1;
            coeffs[row][2*half]     = csr_ch.data[DATA_W-1:0];
            coeffs[row][2*half + 1] = csr_ch.data[CFG_W-1:DATA_W];
         end
         if (req_ch.valid && req_ch.ready) begin
            v[0] = req_ch.vx;
            v[1] = req_ch.vy;
            v[2] = req_ch.vz;
            v[3] = req_ch.vw;
            expected_results.push_back(transform_vertex(coeffs, v));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got[0] = rsp_ch.ox;
            got[1] = rsp_ch.oy;
            got[2] = rsp_ch.oz;
            got[3] = rsp_ch.ow;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %08h %08h %08h %08h with none outstanding",
                                         got[0], got[1], got[2], got[3]));
            end else begin
               want = expected_results.pop_front();
               for (int l = 0; l < LANES; l++) begin
                  if (got[l] !== want[l]) begin
                     report_mismatch($sformatf("result %0d field %s is %08h, expected %08h",
                                               checked, lane_names[l], got[l], want[l]));
                  end
               end
            end
            checked++;
         end
      end
      pending = expected_results.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the vertex transform bench. It drives vertices and matrix writes into the block and
// keeps the result channel's ready moving; all prediction and comparison lives in the checker
// instance, which hands back a failure count and the number of results still outstanding.
module tb;
   import vt4_pkg::*;

   localparam int      FRACTION_BITS   = DEFAULT_FRACTION_BITS;
   localparam fix_type ONE_Q16         = 32'sh0001_0000;
   localparam fix_type HALF_Q16        = 32'sh0000_8000;
   localparam int      PHASES          = 8;
   localparam int      ITEMS_PER_PHASE = 240;
   localparam int      HOLD_OFF_CYCLES = 300;
   localparam int      WATCHDOG_LIMIT  = 4000;
   localparam int      DRAIN_CYCLES    = 8;
   localparam int      SMALL_SPAN      = 1 << 20;
   localparam int      ENTRY_SPAN      = 1 << 18;

   // Kinds of matrix built for the directed and random phases.
   typedef enum int {
      MAT_IDENTITY,
      MAT_ALL_MAX,
      MAT_ALL_MIN,
      MAT_FULL,
      MAT_SMALL,
      MAT_MIXED
   } matrix_kind_type;

   logic clock;
   logic reset;

   vt4_req_if req_ch ();
   vt4_rsp_if rsp_ch ();
   vt4_csr_if csr_ch ();

   int fail_count;
   int pending;
   int checked;

   // Shared controls between the sender and the receiver process.
   bit idle_on;
   bit hold_req;

   int vertices_sent;
   int matrix_loads;
   int idle_cycles;

   vertex_transform_4x4 #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   vt4_transform_checker #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The watchdog counts cycles in which no channel moves an item. The longest quiet
   // stretch in a correct run is the receiver hold-off, so the limit is well above it.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", pending);
         $display("[vertex_transform_4x4] ERROR");
         $finish;
      end
   end

   // Result side. Each pass through the loop makes one assignment to ready and holds it until
   // a later falling edge. A hold request from the stimulus process turns into a
   // long stall that this process counts out on its own, so the pipeline fills and the
   // block has to push back on the vertex channel.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offers one vertex, starting at a falling edge, and returns at the falling edge after
   // the item was taken. Within this task, valid is only dropped when an idle burst is
   // inserted, so back to back items keep valid high without a glitch.
   task automatic send_vertex(input fix_type x, input fix_type y, input fix_type z,
                              input fix_type w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vx    <= x;
      req_ch.vy    <= y;
      req_ch.vz    <= z;
      req_ch.vw    <= w;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      vertices_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [CFG_W-1:0] value);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= reg_index;
      csr_ch.data      <= value;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      @(negedge clock);
   endtask

   // Writes all eight registers in a shuffled order, then one write to an index past the
   // last register, which the block must drop without touching the matrix.
   task automatic load_matrix(input matrix_type m);
      int order[REG_COUNT];
      int j;
      int tmp;
      int row;
      int half;
      for (int i = 0; i < REG_COUNT; i++) begin
         order[i] = i;
      end
      for (int i = REG_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < REG_COUNT; i++) begin
         row  = order[i] >> 1;
         half = order[i] & 1;
         write_register(CSR_INDEX_W'(order[i]), {m[row][2*half + 1], m[row][2*half]});
      end
      write_register(CSR_INDEX_W'($urandom_range(REG_COUNT, (1 << CSR_INDEX_W) - 1)),
                     {$urandom, $urandom});
      csr_ch.valid <= 1'b0;
      matrix_loads++;
   endtask

   // The matrix may only change once every result is back; each vertex gives exactly one
   // result, so an empty expectation store means an empty pipeline. The vertex channel
   // stops offering first so that nothing new enters while the pipeline drains.
   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic fix_type corner_value();
      case ($urandom_range(0, 6))
         0: return FIX_MAX;
         1: return FIX_MIN;
         2: return '0;
         3: return 32'sd1;
         4: return -32'sd1;
         5: return ONE_Q16;
         default: return -ONE_Q16;
      endcase
   endfunction

   // Component mix: full-width noise, values of moderate size that mostly stay in range
   // after the transform, and corner values.
   function automatic fix_type random_component();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         return fix_type'($urandom);
      end else if (pick < 8) begin
         return fix_type'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
      end
      return corner_value();
   endfunction

   function automatic matrix_type build_matrix(input matrix_kind_type kind);
      matrix_type m;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            case (kind)
               MAT_IDENTITY: m[r][c] = (r == c) ? ONE_Q16 : fix_type'(0);
               MAT_ALL_MAX:  m[r][c] = FIX_MAX;
               MAT_ALL_MIN:  m[r][c] = FIX_MIN;
               MAT_FULL:     m[r][c] = fix_type'($urandom);
               MAT_SMALL:
                  m[r][c] = fix_type'(int'($urandom_range(0, 2 * ENTRY_SPAN)) - ENTRY_SPAN);
               default:      m[r][c] = random_component();
            endcase
         end
      end
      return m;
   endfunction

   initial begin
      matrix_kind_type phase_kinds[PHASES];
      matrix_type      m;
      phase_kinds = '{MAT_SMALL, MAT_FULL, MAT_MIXED, MAT_ALL_MAX,
                      MAT_SMALL, MAT_ALL_MIN, MAT_MIXED, MAT_FULL};

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.vx        = '0;
      req_ch.vy        = '0;
      req_ch.vz        = '0;
      req_ch.vw        = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.data      = '0;
      idle_on          = 1'b1;
      hold_req         = 1'b0;
      vertices_sent    = 0;
      matrix_loads     = 1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The reset matrix is the identity, so every vertex comes back
      // unchanged, including the extreme components.
      send_vertex('0, '0, '0, '0);
      send_vertex(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
      send_vertex(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
      send_vertex(FIX_MAX, FIX_MIN, 32'sd1, -32'sd1);
      send_vertex(ONE_Q16, -ONE_Q16, HALF_Q16, -HALF_Q16);
      wait_all_results();

      // Every entry at the positive limit: large vertices saturate in both directions,
      // and mixed signs cancel back into range.
      load_matrix(build_matrix(MAT_ALL_MAX));
      send_vertex(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
      send_vertex(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
      send_vertex(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
      send_vertex(32'sd1, '0, '0, '0);
      wait_all_results();

      // Every entry at the negative limit. The all-minimum vertex gives the largest
      // possible sum, four products of two to the 62nd.
      load_matrix(build_matrix(MAT_ALL_MIN));
      send_vertex(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
      send_vertex(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
      send_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
      wait_all_results();

      // Half-unit entries: a sum of minus half an LSB must floor to minus one LSB, while
      // plus half an LSB truncates to zero.
      m       = build_matrix(MAT_IDENTITY);
      m[0][0] = HALF_Q16;
      m[1]    = '{HALF_Q16, HALF_Q16, HALF_Q16, HALF_Q16};
      m[2][2] = -HALF_Q16;
      m[3][3] = HALF_Q16;
      load_matrix(m);
      send_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
      send_vertex(32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_vertex(-32'sd3, 32'sd3, -32'sd1, '0);
      wait_all_results();

      // An all-zero matrix wipes out even the largest vertex.
      load_matrix('0);
      send_vertex(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
      send_vertex(random_component(), random_component(), random_component(),
                  random_component());
      wait_all_results();

      // Random phases, each under a new matrix. Two of them include a long receiver
      // hold-off while vertices keep coming; the last phase runs with no idling at all.
      for (int phase = 0; phase < PHASES; phase++) begin
         load_matrix(build_matrix(phase_kinds[phase]));
         idle_on = (phase != PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ((phase == 1 || phase == 4) && n == 40) begin
               hold_req = 1'b1;
            end
            send_vertex(random_component(), random_component(), random_component(),
                        random_component());
         end
         wait_all_results();
      end

      // Let any stray result that the block might still produce show up in the checker.
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d vertices under %0d matrix settings; %0d results compared.",
               vertices_sent, matrix_loads, checked);
      $display("Included saturating and floor cases, receiver hold-offs and random idling.");
      if (fail_count == 0 && pending == 0) begin
         $display("[vertex_transform_4x4] OK");
      end else begin
         $display("[vertex_transform_4x4] ERROR");
      end
      $finish;
   end

endmodule
